/* src/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the pose frame receiver: frame delimiters,
// payload geometry and the parser phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  // Frame delimiter bytes
  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  // Payload geometry: six little-endian 32-bit words
  localparam int PAYLOAD_LEN = 24;
  localparam int WORD_COUNT  = 6;
  localparam int WORD_BYTES  = PAYLOAD_LEN / WORD_COUNT;
  localparam int IDX_W       = $clog2(PAYLOAD_LEN);

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_WAIT_LF  = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_TRAIL_LF = 3'd3,
    PH_TRAIL_CR = 3'd4
  } parse_phase_t;

  typedef logic [31:0] frame_word_t;

endpackage : pfr_pkg

`default_nettype wire

/* src/pose_frame_receiver.sv */
// ----------------------------------------------------------------------------
// pose_frame_receiver
// Byte-stream parser for CR LF, 24 payload bytes, LF CR frames. A frame with
// a good trailer is emitted as six raw 32-bit words in one transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  rx      | rx_valid / rx_ready    | rx_byte[7:0]
//  frame   | frame_valid / frame_ready | z/x/y_angle_bits, x/y_position_bits,
//          |                        | yaw_rate_bits (32 bits each)
//
//  One byte is accepted per cycle while rx_ready is high; the phase update and
//  payload write are registered straight from rx into the state registers.
//  A finished frame appears on the frame channel the cycle after its closing
//  CR byte is accepted and is held in the output register until taken.
//  rx_ready drops only while a frame waits and the parser sits at the final
//  trailer byte, which could produce the next frame.
//  Synchronous reset returns the parser to hunting and empties the output.
//
`default_nettype none

module pose_frame_receiver (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 rx_valid,
  output logic                rx_ready,
  input  wire  [7:0]          rx_byte,
  output logic                frame_valid,
  input  wire                 frame_ready,
  output pfr_pkg::frame_word_t z_angle_bits,
  output pfr_pkg::frame_word_t x_angle_bits,
  output pfr_pkg::frame_word_t y_angle_bits,
  output pfr_pkg::frame_word_t x_position_bits,
  output pfr_pkg::frame_word_t y_position_bits,
  output pfr_pkg::frame_word_t yaw_rate_bits
);
  import pfr_pkg::*;

  parse_phase_t      phase, phase_next;
  logic [IDX_W-1:0]  payload_index, payload_index_next;
  logic [7:0]        payload_store [PAYLOAD_LEN];
  frame_word_t       frame_word [WORD_COUNT];

  logic rx_fire;
  logic store_en;
  logic frame_load;

  // Stall input only when the next byte could complete a frame that has nowhere to go
  assign rx_ready = !(frame_valid && !frame_ready && (phase == PH_TRAIL_CR));
  assign rx_fire  = rx_valid && rx_ready;

  // Phase and index update for one received byte
  always_comb begin
    phase_next         = phase;
    payload_index_next = payload_index;
    store_en           = 1'b0;
    frame_load         = 1'b0;
    if (rx_fire) begin
      unique case (phase)
        PH_HUNT: begin
          phase_next = (rx_byte == CR_BYTE) ? PH_WAIT_LF : PH_HUNT;
        end
        PH_WAIT_LF: begin
          if (rx_byte == LF_BYTE) begin
            payload_index_next = '0;
            phase_next         = PH_PAYLOAD;
          end else if (rx_byte != CR_BYTE) begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          store_en = (payload_index < IDX_W'(PAYLOAD_LEN));
          if (payload_index >= IDX_W'(PAYLOAD_LEN - 1)) begin
            payload_index_next = '0;
            phase_next         = PH_TRAIL_LF;
          end else begin
            payload_index_next = payload_index + 1'b1;
          end
        end
        PH_TRAIL_LF: begin
          phase_next = (rx_byte == LF_BYTE) ? PH_TRAIL_CR : PH_HUNT;
        end
        PH_TRAIL_CR: begin
          phase_next = PH_HUNT;
          frame_load = (rx_byte == CR_BYTE);
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_index <= '0;
    end else begin
      phase         <= phase_next;
      payload_index <= payload_index_next;
    end
  end

  // Write payload bytes into the frame buffer
  always_ff @(posedge clk) begin
    if (store_en) begin
      payload_store[payload_index] <= rx_byte;
    end
  end

  // Output valid: set on a good trailer, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_load) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  // Latch the six little-endian words of a completed frame
  always_ff @(posedge clk) begin
    if (frame_load) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        frame_word[k] <= {payload_store[k*WORD_BYTES + 3],
                          payload_store[k*WORD_BYTES + 2],
                          payload_store[k*WORD_BYTES + 1],
                          payload_store[k*WORD_BYTES]};
      end
    end
  end

  assign z_angle_bits    = frame_word[0];
  assign x_angle_bits    = frame_word[1];
  assign y_angle_bits    = frame_word[2];
  assign x_position_bits = frame_word[3];
  assign y_position_bits = frame_word[4];
  assign yaw_rate_bits   = frame_word[5];

endmodule : pose_frame_receiver

`default_nettype wire

/* src/pfr_checker.sv */
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks for the pose frame receiver, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 rx_valid,
  input wire                 rx_ready,
  input wire  [7:0]          rx_byte,
  input wire                 frame_valid,
  input wire                 frame_ready,
  input wire pfr_pkg::frame_word_t z_angle_bits,
  input wire pfr_pkg::frame_word_t x_angle_bits,
  input wire pfr_pkg::frame_word_t y_angle_bits,
  input wire pfr_pkg::frame_word_t x_position_bits,
  input wire pfr_pkg::frame_word_t y_position_bits,
  input wire pfr_pkg::frame_word_t yaw_rate_bits
);
  import pfr_pkg::*;

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !frame_valid)
    else $error("frame_valid high after reset");

  // A stalled frame transaction keeps its words
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(z_angle_bits)
      && $stable(x_angle_bits) && $stable(y_angle_bits)
      && $stable(x_position_bits) && $stable(y_position_bits)
      && $stable(yaw_rate_bits))
    else $error("frame payload changed while stalled");

  // A new frame only follows an accepted closing CR byte
  a_frame_after_cr: assert property (@(posedge clk) disable iff (rst)
    frame_valid && $past(!frame_valid || frame_ready) |->
      $past(rx_valid && rx_ready && rx_byte == CR_BYTE))
    else $error("frame emitted without a closing CR");

  // Input is never stalled while the output is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !frame_valid |-> rx_ready)
    else $error("rx stalled with empty output");

endmodule : pfr_checker

bind pose_frame_receiver pfr_checker u_pfr_checker (.*);

`default_nettype wire
